// ----- rtl/core/field_grid_interpolator_core_defines.svh -----
// Assertion macros shared by the field grid interpolator RTL.
// Depends on nothing; included by the top level only.
`ifndef FIELD_GRID_INTERPOLATOR_CORE_DEFINES_SVH
`define FIELD_GRID_INTERPOLATOR_CORE_DEFINES_SVH
// Consequent checked in the same cycle as the antecedent.
`define FGI_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Consequent checked in the cycle after the antecedent.
`define FGI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ----- rtl/core/fgi_pkg.sv -----
// Package of the field grid interpolator: payload and control types, codes,
// default parameters and the output saturation function. Depends on nothing.
`timescale 1ns / 1ps
package fgi_pkg;

    localparam int TABLE_ENTRIES_DEF = 1048576;
    localparam int FIELD_BITS_DEF    = 16;
    localparam logic [15:0] SCALE_RESET = 16'd16384;

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_NEAREST = 2'd1,
        OP_TRILIN  = 2'd2,
        OP_GRAD    = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        CFG_ORIGIN_X   = 3'd0,
        CFG_ORIGIN_Y   = 3'd1,
        CFG_ORIGIN_Z   = 3'd2,
        CFG_INV_STEP_X = 3'd3,
        CFG_INV_STEP_Y = 3'd4,
        CFG_INV_STEP_Z = 3'd5,
        CFG_SCALE      = 3'd6,
        CFG_GRID_DIMS  = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        t_op                opcode;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [19:0]        entry_index;
        logic signed [15:0] entry_bx;
        logic signed [15:0] entry_by;
        logic signed [15:0] entry_bz;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] val_x;
        logic signed [31:0] val_y;
        logic signed [31:0] val_z;
        logic               in_range;
        logic               last;
    } t_out_item;

    typedef struct packed {
        logic [2:0][31:0]   origin;
        logic [2:0][31:0]   inv_step;
        logic signed [15:0] scale;
        logic [29:0]        dims;
    } t_cfg;

    // Load data, sign extended to the widest supported field.
    typedef struct packed {
        logic [19:0]      idx;
        logic [2:0][23:0] data;
    } t_load;

    // Front end to table and arithmetic: corner addresses and weights.
    // Slot k is corner (x + k[0], y + k[1], z + k[2]).
    typedef struct packed {
        logic             valid;
        t_op              op;
        logic             inr;
        logic [7:0][31:0] addr;
        logic [7:0][16:0] wt;
        t_load            ld;
        logic             ld_ok;
    } t_front;

    // Arithmetic to output: up to three result rows.
    typedef struct packed {
        logic                  valid;
        t_op                   op;
        logic                  inr;
        logic [2:0][2:0][31:0] row;
    } t_res;

    function automatic logic [31:0] sat32(input logic signed [63:0] v);
        logic [31:0] r;
        if (v > 64'sd2147483647) r = 32'h7FFF_FFFF;
        else if (v < -64'sd2147483648) r = 32'h8000_0000;
        else r = v[31:0];
        return r;
    endfunction

endpackage

// ----- rtl/core/fgi_addr.sv -----
// Front end: grid coordinates, range checks, corner addresses and weights.
// Depends on fgi_pkg.
`timescale 1ns / 1ps
module fgi_addr import fgi_pkg::*; #(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_in_item i_item,
    input  t_cfg     i_cfg,
    output t_front   o_front
);
    localparam logic [32:0] TE = 33'(TABLE_ENTRIES);

    // Stage A: accepted item.
    logic     r_a_vld;
    t_in_item r_a_item;
    // Stage B: offset from origin.
    logic             r_b_vld;
    t_op              r_b_op;
    t_load            r_b_ld;
    logic [2:0][31:0] r_b_dm;
    logic [2:0]       r_b_neg;
    // Stage C: grid coordinate, Q.32.
    logic             r_c_vld;
    t_op              r_c_op;
    t_load            r_c_ld;
    logic [2:0][63:0] r_c_u;
    logic [2:0]       r_c_neg;
    // Stage D: cell and fractions.
    logic             r_d_vld;
    t_op              r_d_op;
    t_load            r_d_ld;
    logic             r_d_inr;
    logic [2:0][9:0]  r_d_g;
    logic [2:0][15:0] r_d_f;
    logic [2:0][9:0]  r_d_n;
    // Stage E: partial products.
    logic             r_e_vld;
    t_op              r_e_op;
    t_load            r_e_ld;
    logic             r_e_inr;
    logic [19:0]      r_e_p1;
    logic [19:0]      r_e_n01;
    logic [9:0]       r_e_n0;
    logic [9:0]       r_e_g0;
    logic [9:0]       r_e_g1;
    logic [15:0]      r_e_fz;
    logic [3:0][33:0] r_e_hxy;
    // Stage F: base index and weights.
    logic             r_f_vld;
    t_op              r_f_op;
    t_load            r_f_ld;
    logic             r_f_inr;
    logic [31:0]      r_f_base;
    logic [19:0]      r_f_n01;
    logic [9:0]       r_f_n0;
    logic [7:0][16:0] r_f_w;
    // Stage G: output.
    t_front r_g;

    logic [2:0][31:0] w_pos;
    logic [2:0][32:0] w_d;
    logic [2:0][32:0] w_g;
    logic [2:0][64:0] w_rnd;
    logic [2:0]       w_ok;
    logic [2:0][9:0]  w_n;
    logic [1:0][16:0] w_hx;
    logic [1:0][16:0] w_hy;
    logic [1:0][16:0] w_hz;
    logic [20:0]      w_s;
    logic [7:0][50:0] w_pw;
    logic [7:0][31:0] w_addr;
    logic             w_bound;

    assign w_pos = {r_a_item.pos_z, r_a_item.pos_y, r_a_item.pos_x};

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_d[a] = {w_pos[a][31], w_pos[a]} - {i_cfg.origin[a][31], i_cfg.origin[a]};
            w_n[a] = i_cfg.dims[10*a +: 10];
            w_rnd[a] = {1'b0, r_c_u[a]} + 65'h0_8000_0000;
            if (r_c_op == OP_NEAREST) begin
                w_g[a] = w_rnd[a][64:32];
                w_ok[a] = w_g[a] < {23'd0, w_n[a]};
            end else begin
                w_g[a] = {1'b0, r_c_u[a][63:32]};
                w_ok[a] = ({1'b0, w_g[a]} + 34'd1) < {24'd0, w_n[a]};
            end
            w_ok[a] = w_ok[a] && !r_c_neg[a];
        end
    end

    always_comb begin
        w_hx[1] = {1'b0, r_d_f[0]};
        w_hx[0] = 17'h10000 - w_hx[1];
        w_hy[1] = {1'b0, r_d_f[1]};
        w_hy[0] = 17'h10000 - w_hy[1];
        w_hz[1] = {1'b0, r_e_fz};
        w_hz[0] = 17'h10000 - w_hz[1];
        w_s = 21'(r_e_p1) + 21'(r_e_g1);
        for (int k = 0; k < 8; k++) begin
            w_pw[k] = 51'(r_e_hxy[k % 4]) * 51'(w_hz[k / 4]);
        end
    end

    always_comb begin
        w_addr[0] = r_f_base;
        w_addr[1] = r_f_base + 32'd1;
        w_addr[2] = r_f_base + 32'(r_f_n0);
        w_addr[3] = r_f_base + 32'(r_f_n0) + 32'd1;
        w_addr[4] = r_f_base + 32'(r_f_n01);
        w_addr[5] = w_addr[4] + 32'd1;
        w_addr[6] = w_addr[4] + 32'(r_f_n0);
        w_addr[7] = w_addr[4] + 32'(r_f_n0) + 32'd1;
        case (r_f_op)
            OP_NEAREST: w_bound = {1'b0, w_addr[0]} < TE;
            OP_TRILIN:  w_bound = {1'b0, w_addr[7]} < TE;
            default:    w_bound = {1'b0, w_addr[4]} < TE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
            r_f_vld <= 1'b0;
        end else begin
            r_a_vld <= i_valid;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_d_vld <= r_c_vld;
            r_e_vld <= r_d_vld;
            r_f_vld <= r_e_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_item <= i_item;

        r_b_op <= r_a_item.opcode;
        r_b_ld.idx <= r_a_item.entry_index;
        r_b_ld.data[0] <= 24'(r_a_item.entry_bx);
        r_b_ld.data[1] <= 24'(r_a_item.entry_by);
        r_b_ld.data[2] <= 24'(r_a_item.entry_bz);
        for (int a = 0; a < 3; a++) begin
            r_b_dm[a] <= w_d[a][31:0];
            r_b_neg[a] <= w_d[a][32];
        end

        r_c_op <= r_b_op;
        r_c_ld <= r_b_ld;
        r_c_neg <= r_b_neg;
        for (int a = 0; a < 3; a++) begin
            r_c_u[a] <= r_b_neg[a] ? 64'd0 : 64'(r_b_dm[a]) * 64'(i_cfg.inv_step[a]);
        end

        r_d_op <= r_c_op;
        r_d_ld <= r_c_ld;
        r_d_inr <= &w_ok;
        for (int a = 0; a < 3; a++) begin
            r_d_g[a] <= w_g[a][9:0];
            r_d_f[a] <= r_c_u[a][31:16];
            r_d_n[a] <= w_n[a];
        end

        r_e_op <= r_d_op;
        r_e_ld <= r_d_ld;
        r_e_inr <= r_d_inr;
        r_e_p1 <= 20'(r_d_n[1]) * 20'(r_d_g[2]);
        r_e_n01 <= 20'(r_d_n[0]) * 20'(r_d_n[1]);
        r_e_n0 <= r_d_n[0];
        r_e_g0 <= r_d_g[0];
        r_e_g1 <= r_d_g[1];
        r_e_fz <= r_d_f[2];
        for (int k = 0; k < 4; k++) begin
            r_e_hxy[k] <= 34'(w_hx[k % 2]) * 34'(w_hy[k / 2]);
        end

        r_f_op <= r_e_op;
        r_f_ld <= r_e_ld;
        r_f_inr <= r_e_inr;
        r_f_base <= 32'(w_s) * 32'(r_e_n0) + 32'(r_e_g0);
        r_f_n01 <= r_e_n01;
        r_f_n0 <= r_e_n0;
        for (int k = 0; k < 8; k++) begin
            r_f_w[k] <= 17'((w_pw[k] + 51'h0_8000_0000) >> 32);
        end

        if (!i_rst_n) begin
            r_g.valid <= 1'b0;
        end else begin
            r_g.valid <= r_f_vld;
        end
        r_g.op <= r_f_op;
        r_g.inr <= r_f_inr && w_bound;
        r_g.addr <= w_addr;
        r_g.wt <= r_f_w;
        r_g.ld <= r_f_ld;
        r_g.ld_ok <= {13'd0, r_f_ld.idx} < TE;
    end

    assign o_front = r_g;

endmodule

// ----- rtl/core/fgi_table.sv -----
// Field table: eight replicated memories, one read port each, common write.
// Depends on fgi_pkg.
`timescale 1ns / 1ps
module fgi_table import fgi_pkg::*; #(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int FIELD_BITS    = FIELD_BITS_DEF
) (
    input  logic                            i_clk,
    input  t_front                          i_front,
    output logic [7:0][2:0][FIELD_BITS-1:0] o_rd
);
    localparam int AW = $clog2(TABLE_ENTRIES);

    logic                            w_we;
    logic [AW-1:0]                   w_waddr;
    logic [3*FIELD_BITS-1:0]         w_wdata;
    logic [7:0][2:0][FIELD_BITS-1:0] r_rd;

    assign w_we = i_front.valid && (i_front.op == OP_LOAD) && i_front.ld_ok;
    assign w_waddr = AW'(i_front.ld.idx);
    assign w_wdata = {i_front.ld.data[2][FIELD_BITS-1:0],
                      i_front.ld.data[1][FIELD_BITS-1:0],
                      i_front.ld.data[0][FIELD_BITS-1:0]};

    for (genvar k = 0; k < 8; k++) begin : g_bank
        logic [3*FIELD_BITS-1:0] mem [TABLE_ENTRIES];
        always_ff @(posedge i_clk) begin
            if (w_we) begin
                mem[w_waddr] <= w_wdata;
            end
            r_rd[k] <= mem[i_front.addr[k][AW-1:0]];
        end
    end

    assign o_rd = r_rd;

endmodule

// ----- rtl/core/fgi_math.sv -----
// Back end arithmetic: nearest scaling, trilinear sum, gradient differences,
// rounding and saturation. Depends on fgi_pkg.
`timescale 1ns / 1ps
module fgi_math import fgi_pkg::*; #(
    parameter int FIELD_BITS = FIELD_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  t_front                          i_front,
    input  logic [7:0][2:0][FIELD_BITS-1:0] i_rd,
    input  t_cfg                            i_cfg,
    output t_res                            o_res
);
    localparam int PW  = FIELD_BITS + 18;  // weight times entry
    localparam int SW  = PW + 1;           // pair sum
    localparam int AW  = PW + 3;           // eight-corner sum
    localparam int XW  = AW + 16;          // sum times scale
    localparam int NW  = FIELD_BITS + 16;  // nearest product
    localparam int DW  = FIELD_BITS + 1;   // difference
    localparam int TW  = FIELD_BITS + 17;  // difference times scale
    localparam int QW  = TW + 16;          // magnitude times half of inv_step

    // Control per stage.
    logic [4:1] r_vld;
    t_op  [4:0] r_op;
    logic [4:0] r_inr;
    logic [7:0][16:0] r0_wt;

    logic signed [PW-1:0] r1_pr [8][3];
    logic signed [NW-1:0] r1_np [3];
    logic signed [DW-1:0] r1_dd [3][3];
    logic r0_vld;

    logic signed [SW-1:0] r2_s [4][3];
    logic signed [NW-1:0] r2_np [3];
    logic signed [TW-1:0] r2_t [3][3];

    logic signed [AW-1:0] r3_acc [3];
    logic signed [NW-1:0] r3_np [3];
    logic [TW-1:0]        r3_m [3][3];
    logic                 r3_neg [3][3];

    logic signed [XW-1:0] r4_x [3];
    logic signed [NW-1:0] r4_np [3];
    logic [QW-1:0]        r4_p [3][3];
    logic [QW-1:0]        r4_q [3][3];
    logic                 r4_neg [3][3];

    t_res r5;

    logic signed [FIELD_BITS-1:0] w_e [8][3];
    logic signed [63:0]           w_x64 [3];
    logic [63:0]                  w_mag [3];
    logic signed [63:0]           w_tri [3];
    logic [63:0]                  w_r [3][3];
    logic signed [63:0]           w_grd [3][3];
    logic [2:0][2:0][31:0]        w_row;

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            for (int c = 0; c < 3; c++) begin
                w_e[k][c] = $signed(i_rd[k][c]);
            end
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            // Trilinear: magnitude rounding of the scaled sum, half away from zero.
            w_x64[c] = 64'(r4_x[c]);
            w_mag[c] = w_x64[c][63] ? 64'(-w_x64[c]) : 64'(w_x64[c]);
            w_mag[c] = (w_mag[c] + 64'd8192) >> 14;
            w_tri[c] = w_x64[c][63] ? -$signed(w_mag[c]) : $signed(w_mag[c]);
        end
        for (int a = 0; a < 3; a++) begin
            for (int c = 0; c < 3; c++) begin
                w_r[a][c] = (64'(r4_p[a][c]) + ((64'(r4_q[a][c]) + 64'h20_0000) >> 16)) >> 6;
                if (w_r[a][c] > 64'h100_0000_0000) w_r[a][c] = 64'h100_0000_0000;
                w_grd[a][c] = r4_neg[a][c] ? -$signed(w_r[a][c]) : $signed(w_r[a][c]);
            end
        end
        w_row = '0;
        for (int c = 0; c < 3; c++) begin
            case (r_op[4])
                OP_NEAREST: w_row[0][c] = sat32(64'(r4_np[c]) <<< 2);
                OP_TRILIN:  w_row[0][c] = sat32(w_tri[c]);
                default: begin
                    for (int a = 0; a < 3; a++) w_row[a][c] = sat32(w_grd[a][c]);
                end
            endcase
        end
        if (!r_inr[4]) w_row = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
            r_vld <= '0;
        end else begin
            r0_vld <= i_front.valid && (i_front.op != OP_LOAD);
            r_vld <= {r_vld[3:1], r0_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r_op[0] <= i_front.op;
        r_inr[0] <= i_front.inr;
        r0_wt <= i_front.wt;
        for (int s = 1; s < 5; s++) begin
            r_op[s] <= r_op[s-1];
            r_inr[s] <= r_inr[s-1];
        end

        for (int c = 0; c < 3; c++) begin
            for (int k = 0; k < 8; k++) begin
                r1_pr[k][c] <= $signed({1'b0, r0_wt[k]}) * w_e[k][c];
            end
            r1_np[c] <= w_e[0][c] * i_cfg.scale;
            for (int a = 0; a < 3; a++) begin
                r1_dd[a][c] <= DW'(w_e[1 << a][c]) - DW'(w_e[0][c]);
            end
        end

        for (int c = 0; c < 3; c++) begin
            for (int j = 0; j < 4; j++) begin
                r2_s[j][c] <= SW'(r1_pr[2*j][c]) + SW'(r1_pr[2*j+1][c]);
            end
            r2_np[c] <= r1_np[c];
            for (int a = 0; a < 3; a++) begin
                r2_t[a][c] <= r1_dd[a][c] * i_cfg.scale;
            end
        end

        for (int c = 0; c < 3; c++) begin
            r3_acc[c] <= AW'(r2_s[0][c]) + AW'(r2_s[1][c]) + AW'(r2_s[2][c])
                       + AW'(r2_s[3][c]);
            r3_np[c] <= r2_np[c];
            for (int a = 0; a < 3; a++) begin
                r3_neg[a][c] <= r2_t[a][c][TW-1];
                r3_m[a][c] <= r2_t[a][c][TW-1] ? TW'(-r2_t[a][c]) : TW'(r2_t[a][c]);
            end
        end

        for (int c = 0; c < 3; c++) begin
            r4_x[c] <= r3_acc[c] * i_cfg.scale;
            r4_np[c] <= r3_np[c];
            for (int a = 0; a < 3; a++) begin
                r4_neg[a][c] <= r3_neg[a][c];
                r4_p[a][c] <= QW'(r3_m[a][c]) * QW'(i_cfg.inv_step[a][31:16]);
                r4_q[a][c] <= QW'(r3_m[a][c]) * QW'(i_cfg.inv_step[a][15:0]);
            end
        end

        if (!i_rst_n) begin
            r5.valid <= 1'b0;
        end else begin
            r5.valid <= r_vld[4];
        end
        r5.op <= r_op[4];
        r5.inr <= r_inr[4];
        r5.row <= w_row;
    end

    assign o_res = r5;

endmodule

// ----- rtl/core/field_grid_interpolator_core.sv -----
// Top level of the field grid interpolator: configuration registers, issue
// control, result serializer and assertions. Depends on fgi_pkg, fgi_addr,
// fgi_table, fgi_math and the shared assertion macro header.
`timescale 1ns / 1ps
`include "field_grid_interpolator_core_defines.svh"

// A command is taken at a rising edge with start high and busy low. Load,
// nearest and trilinear commands can be issued in every cycle; a gradient
// command raises busy for the issue slots of its second and third results,
// because it returns three results on consecutive cycles. A result passes
// through fourteen register stages, the first of which captures the command
// at the edge that takes it: seven front-end stages for coordinates and
// addresses, one table read, five arithmetic stages and the output register.
// Each result is shown for one cycle under o_strobe. The receiver has no way
// to stall the block, so every result must be captured in the cycle it is
// shown. A load returns nothing and lands in the table in pipeline order, so
// a query issued after a load sees it. The table is eight copies of the field
// memory, all written by each load, so the eight trilinear corners are read
// in the same cycle. Configuration writes are always ready and must only
// happen while no command is in flight.
module field_grid_interpolator_core import fgi_pkg::*; #(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int FIELD_BITS    = FIELD_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_in_item    i_in,
    output logic        o_strobe,
    output t_out_item   o_out,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    t_cfg r_cfg, n_cfg;
    logic [1:0] r_busy_cnt, n_busy_cnt;
    logic w_accept;

    t_front w_front;
    logic [7:0][2:0][FIELD_BITS-1:0] w_rd;
    t_res w_res;

    // The serializer holds the second and third gradient rows.
    logic [1:0][2:0][31:0] r_hold, n_hold;
    logic [1:0] r_cnt, n_cnt;
    logic r_inr, n_inr;
    logic r_strobe, n_strobe;
    t_out_item r_out, n_out;

    assign w_accept = start && !busy;
    assign busy = (r_busy_cnt != 2'd0);
    assign o_cfg_ready = 1'b1;

    // Configuration write transactions.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_ORIGIN_X:   n_cfg.origin[0] = i_cfg_data;
                CFG_ORIGIN_Y:   n_cfg.origin[1] = i_cfg_data;
                CFG_ORIGIN_Z:   n_cfg.origin[2] = i_cfg_data;
                CFG_INV_STEP_X: n_cfg.inv_step[0] = i_cfg_data;
                CFG_INV_STEP_Y: n_cfg.inv_step[1] = i_cfg_data;
                CFG_INV_STEP_Z: n_cfg.inv_step[2] = i_cfg_data;
                CFG_SCALE:      n_cfg.scale = i_cfg_data[15:0];
                CFG_GRID_DIMS:  n_cfg.dims = i_cfg_data[29:0];
                default: ;
            endcase
        end
    end

    // A gradient command keeps issue slots empty for its second and third
    // results.
    always_comb begin
        n_busy_cnt = r_busy_cnt;
        if (w_accept && (i_in.opcode == OP_GRAD)) begin
            n_busy_cnt = 2'd2;
        end else if (r_busy_cnt != 2'd0) begin
            n_busy_cnt = r_busy_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin <= '0;
            r_cfg.inv_step <= '0;
            r_cfg.scale <= SCALE_RESET;
            r_cfg.dims <= '0;
            r_busy_cnt <= 2'd0;
        end else begin
            r_cfg <= n_cfg;
            r_busy_cnt <= n_busy_cnt;
        end
    end

    fgi_addr #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_addr (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(w_accept),
        .i_item (i_in),
        .i_cfg  (r_cfg),
        .o_front(w_front)
    );

    fgi_table #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .FIELD_BITS   (FIELD_BITS)
    ) u_table (
        .i_clk  (i_clk),
        .i_front(w_front),
        .o_rd   (w_rd)
    );

    fgi_math #(
        .FIELD_BITS(FIELD_BITS)
    ) u_math (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_front(w_front),
        .i_rd   (w_rd),
        .i_cfg  (r_cfg),
        .o_res  (w_res)
    );

    // Result serializer. A new result always wins; the issue gap after a
    // gradient command guarantees the held rows have drained by then.
    always_comb begin
        n_strobe = 1'b0;
        n_out = r_out;
        n_hold = r_hold;
        n_cnt = r_cnt;
        n_inr = r_inr;
        if (w_res.valid) begin
            n_strobe = 1'b1;
            n_out.val_x = w_res.row[0][0];
            n_out.val_y = w_res.row[0][1];
            n_out.val_z = w_res.row[0][2];
            n_out.in_range = w_res.inr;
            n_out.last = (w_res.op != OP_GRAD);
            if (w_res.op == OP_GRAD) begin
                n_cnt = 2'd2;
                n_hold[0] = w_res.row[1];
                n_hold[1] = w_res.row[2];
                n_inr = w_res.inr;
            end
        end else if (r_cnt != 2'd0) begin
            n_strobe = 1'b1;
            n_out.val_x = r_hold[0][0];
            n_out.val_y = r_hold[0][1];
            n_out.val_z = r_hold[0][2];
            n_out.in_range = r_inr;
            n_out.last = (r_cnt == 2'd1);
            n_hold[0] = r_hold[1];
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_strobe <= n_strobe;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        r_hold <= n_hold;
        r_inr <= n_inr;
    end

    assign o_strobe = r_strobe;
    assign o_out = r_out;

    // A gradient command must block the following issue slot.
    `FGI_ASSERT_NEXT(a_grad_busy, i_clk, i_rst_n, w_accept && (i_in.opcode == OP_GRAD), busy, "gradient command did not raise busy")
    // A new result must never arrive while gradient rows are still held.
    `FGI_ASSERT_SAME(a_no_overlap, i_clk, i_rst_n, w_res.valid, r_cnt == 2'd0, "result arrived while gradient rows pending")
    // Held rows are always delivered in the next cycle.
    `FGI_ASSERT_NEXT(a_drain, i_clk, i_rst_n, r_cnt != 2'd0, o_strobe, "held gradient row not delivered")
    // An out-of-range result carries zero values.
    `FGI_ASSERT_SAME(a_zero_oor, i_clk, i_rst_n, o_strobe && !o_out.in_range, (o_out.val_x == 32'sd0) && (o_out.val_y == 32'sd0) && (o_out.val_z == 32'sd0), "out-of-range result not zero")

endmodule

// ----- tb/sv/field_grid_interpolator_core_tb.sv -----
// Self-checking testbench of field_grid_interpolator_core: directed and random
// load, nearest, trilinear and gradient transactions checked against a predictor.
// Depends on fgi_pkg and the core RTL.
`timescale 1ns / 1ps

module field_grid_interpolator_core_tb;
    import fgi_pkg::*;

    localparam longint TABLE_SIZE = 1048576;
    localparam int     CYCLE_LIMIT = 200000;
    localparam int     DRAIN_CYCLES = 24;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_in_item    i_in = '0;
    logic        o_strobe;
    t_out_item   o_out;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    field_grid_interpolator_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_in       (i_in),
        .o_strobe   (o_strobe),
        .o_out      (o_out),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Shadow of the configuration registers and of the written table entries.
    longint      grid_origin [3];
    logic [31:0] grid_inv [3];
    longint      field_gain;
    logic [29:0] grid_size;
    logic [47:0] field_mem [longint unsigned];

    t_in_item  cmd_q [$];
    t_out_item field_exp_q [$];

    int n_accepted = 0;
    int n_taken = 0;
    int n_queries = 0;
    int n_results = 0;
    int n_mismatch = 0;
    int n_phases = 0;
    int cycles = 0;
    int gap_left = 0;
    int burst_left = 0;

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Shift right with rounding half away from zero, on the magnitude.
    function automatic longint shift_round(longint x, int s);
        bit neg;
        longint unsigned m;
        neg = x < 0;
        m = neg ? longint'(-x) : x;
        m = (m + (64'd1 << (s - 1))) >> s;
        return neg ? -longint'(m) : longint'(m);
    endfunction

    // Q.14 difference times a Q8.24 inverse step, giving Q.16.
    function automatic longint step_product(longint t, logic [31:0] inv);
        bit neg;
        logic [63:0] m, p, q, r;
        neg = t < 0;
        m = neg ? 64'(-t) : 64'(t);
        p = m * 64'(inv[31:16]);
        q = m * 64'(inv[15:0]);
        r = (p + ((q + (64'd1 << 21)) >> 16)) >> 6;
        if (r > (64'd1 << 40)) r = 64'd1 << 40;
        return neg ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint field_at(logic [63:0] idx, int c);
        logic [47:0] w;
        w = field_mem.exists(idx) ? field_mem[idx] : 48'd0;
        return longint'($signed(w[c*16 +: 16]));
    endfunction

    function automatic void push_field(longint v [3], bit inr, bit last);
        t_out_item r;
        r.val_x = inr ? 32'(clamp32(v[0])) : 32'sd0;
        r.val_y = inr ? 32'(clamp32(v[1])) : 32'sd0;
        r.val_z = inr ? 32'(clamp32(v[2])) : 32'sd0;
        r.in_range = inr;
        r.last = last;
        field_exp_q.push_back(r);
    endfunction

    // Works out every result that one accepted transaction causes.
    function automatic void predict_field(t_in_item it);
        longint      p [3];
        longint      v [3];
        longint      acc [3];
        logic [63:0] u [3], n [3], g [3], h [3][2];
        logic [63:0] base, w, idx, delta;
        longint      d;
        bit          inr;
        if (it.opcode == OP_LOAD) begin
            field_mem[64'(it.entry_index)] = {it.entry_bz, it.entry_by, it.entry_bx};
            return;
        end
        n_queries++;
        p[0] = it.pos_x;
        p[1] = it.pos_y;
        p[2] = it.pos_z;
        v = '{0, 0, 0};
        inr = 1'b1;
        for (int a = 0; a < 3; a++) begin
            d = p[a] - grid_origin[a];
            n[a] = 64'(grid_size[10*a +: 10]);
            if (d < 0) begin
                inr = 1'b0;
                u[a] = 0;
            end else begin
                u[a] = 64'(d) * 64'(grid_inv[a]);
            end
            if (it.opcode == OP_NEAREST) begin
                g[a] = (u[a] + (64'd1 << 31)) >> 32;
                if (g[a] >= n[a]) inr = 1'b0;
            end else begin
                g[a] = u[a] >> 32;
                if (g[a] + 1 >= n[a]) inr = 1'b0;
            end
        end
        base = inr ? n[0] * (n[1] * g[2] + g[1]) + g[0] : 64'd0;
        case (it.opcode)
            OP_NEAREST: begin
                if (inr && base >= TABLE_SIZE) inr = 1'b0;
                if (inr)
                    for (int c = 0; c < 3; c++) v[c] = field_at(base, c) * field_gain * 4;
                push_field(v, inr, 1'b1);
            end
            OP_TRILIN: begin
                if (inr && base + 1 + n[0] + n[0] * n[1] >= TABLE_SIZE) inr = 1'b0;
                if (inr) begin
                    acc = '{0, 0, 0};
                    for (int a = 0; a < 3; a++) begin
                        h[a][1] = (u[a] >> 16) & 64'hFFFF;
                        h[a][0] = 64'd65536 - h[a][1];
                    end
                    for (int k = 0; k < 8; k++) begin
                        w = (h[0][k&1] * h[1][(k>>1)&1] * h[2][(k>>2)&1]
                             + (64'd1 << 31)) >> 32;
                        idx = base + 64'(k & 1) + n[0] * (64'((k >> 1) & 1)
                              + n[1] * 64'((k >> 2) & 1));
                        for (int c = 0; c < 3; c++)
                            acc[c] += longint'(w) * field_at(idx, c);
                    end
                    for (int c = 0; c < 3; c++) v[c] = shift_round(acc[c] * field_gain, 14);
                end
                push_field(v, inr, 1'b1);
            end
            default: begin
                if (inr && base + n[0] * n[1] >= TABLE_SIZE) inr = 1'b0;
                for (int a = 0; a < 3; a++) begin
                    if (inr) begin
                        delta = (a == 0) ? 64'd1 : (a == 1) ? n[0] : n[0] * n[1];
                        for (int c = 0; c < 3; c++)
                            v[c] = step_product((field_at(base + delta, c)
                                   - field_at(base, c)) * field_gain, grid_inv[a]);
                    end
                    push_field(v, inr, a == 2);
                end
            end
        endcase
    endfunction

    // Driver: a pending transaction is shown after a random gap and held
    // until the block takes it. Gaps come in runs, with bursts of none.
    always @(negedge i_clk) begin
        bit drive;
        bit popped;
        popped = 1'b0;
        if (n_taken != n_accepted) begin
            n_taken = n_accepted;
            void'(cmd_q.pop_front());
            popped = 1'b1;
            if (burst_left > 0) begin
                burst_left--;
                gap_left = 0;
            end else if ($urandom_range(0, 9) == 0) begin
                burst_left = 12;
                gap_left = 0;
            end else begin
                gap_left = $urandom_range(0, 7);
            end
        end
        if (!i_rst_n || cmd_q.size() == 0) begin
            drive = 1'b0;
        end else if (start && !popped) begin
            drive = 1'b1;
        end else if (gap_left > 0) begin
            gap_left--;
            drive = 1'b0;
        end else begin
            drive = 1'b1;
        end
        start <= drive;
        if (drive) i_in <= cmd_q[0];
    end

    // Acceptance, result checking and the cycle limit, all at the rising edge.
    always @(posedge i_clk) begin
        t_out_item e;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, field_exp_q.size());
            $display("[FAIL] regression broken");
            $finish;
        end
        if (i_rst_n && start && !busy) begin
            predict_field(i_in);
            n_accepted++;
        end
        if (i_rst_n && o_strobe) begin
            if (field_exp_q.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("unexpected result x=%0d y=%0d z=%0d inr=%0b last=%0b",
                             o_out.val_x, o_out.val_y, o_out.val_z,
                             o_out.in_range, o_out.last);
            end else begin
                e = field_exp_q.pop_front();
                n_results++;
                if (o_out.val_x !== e.val_x || o_out.val_y !== e.val_y ||
                    o_out.val_z !== e.val_z || o_out.in_range !== e.in_range ||
                    o_out.last !== e.last) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("mismatch: exp x=%0d y=%0d z=%0d inr=%0b last=%0b, %s",
                                 e.val_x, e.val_y, e.val_z, e.in_range, e.last,
                                 $sformatf("got x=%0d y=%0d z=%0d inr=%0b last=%0b",
                                           o_out.val_x, o_out.val_y, o_out.val_z,
                                           o_out.in_range, o_out.last));
                end
            end
        end
    end

    // Waits until no transaction is pending or in flight; loads return
    // nothing, so the pipeline latency is waited out as well.
    task automatic wait_idle();
        while (cmd_q.size() != 0 || field_exp_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [31:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_ORIGIN_X, CFG_ORIGIN_Y, CFG_ORIGIN_Z:
                grid_origin[int'(idx)] = longint'($signed(data));
            CFG_INV_STEP_X, CFG_INV_STEP_Y, CFG_INV_STEP_Z:
                grid_inv[int'(idx) - 3] = data;
            CFG_SCALE:
                field_gain = longint'($signed(data[15:0]));
            default:
                grid_size = data[29:0];
        endcase
    endtask

    task automatic program_grid(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                                logic [31:0] sx, logic [31:0] sy, logic [31:0] sz,
                                logic [15:0] gain, logic [9:0] nx, logic [9:0] ny,
                                logic [9:0] nz);
        wait_idle();
        write_reg(CFG_ORIGIN_X, ox);
        write_reg(CFG_ORIGIN_Y, oy);
        write_reg(CFG_ORIGIN_Z, oz);
        write_reg(CFG_INV_STEP_X, sx);
        write_reg(CFG_INV_STEP_Y, sy);
        write_reg(CFG_INV_STEP_Z, sz);
        write_reg(CFG_SCALE, {16'($urandom_range(0, 65535)), gain});
        write_reg(CFG_GRID_DIMS, {2'($urandom_range(0, 3)), nz, ny, nx});
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        n_phases++;
    endtask

    function automatic t_in_item load_cmd(int idx, logic [15:0] bx, logic [15:0] by,
                                          logic [15:0] bz);
        t_in_item it;
        it = '0;
        it.opcode = OP_LOAD;
        it.pos_x = $urandom;
        it.pos_y = $urandom;
        it.pos_z = $urandom;
        it.entry_index = 20'(idx);
        it.entry_bx = bx;
        it.entry_by = by;
        it.entry_bz = bz;
        return it;
    endfunction

    function automatic t_in_item query_cmd(t_op op, logic [31:0] x, logic [31:0] y,
                                           logic [31:0] z);
        t_in_item it;
        it = load_cmd($urandom_range(0, 1048575), 16'($urandom), 16'($urandom),
                      16'($urandom));
        it.opcode = op;
        it.pos_x = x;
        it.pos_y = y;
        it.pos_z = z;
        return it;
    endfunction

    // Random query: mostly positions aimed inside the grid, now and then just
    // below the origin, and a share of fully random positions.
    function automatic t_in_item random_query();
        t_op         op;
        longint      p [3];
        longint unsigned lim;
        longint      d;
        bit          noise;
        op = t_op'($urandom_range(1, 3));
        noise = $urandom_range(0, 4) == 0;
        for (int a = 0; a < 3; a++) begin
            if (noise) begin
                p[a] = longint'($urandom);
            end else begin
                lim = (grid_inv[a] == 0) ? 64'd4096
                    : ((64'(grid_size[10*a +: 10]) + 1) << 32) / grid_inv[a];
                if (lim > (64'd1 << 30)) lim = 64'd1 << 30;
                d = longint'($urandom_range(0, 32'(lim)));
                if ($urandom_range(0, 15) == 0) d = -longint'($urandom_range(1, 300));
                p[a] = grid_origin[a] + d;
            end
        end
        return query_cmd(op, 32'(p[0]), 32'(p[1]), 32'(p[2]));
    endfunction

    initial begin
        int nx, ny, nz;
        logic [31:0] inv [3];
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. The largest grid is used, with only the corners of
        // the first cell written, so queries either hit those entries or are
        // rejected as outside the grid or beyond the end of the table.
        program_grid(32'h8000_0000, 32'd0, 32'h7FFF_FFFF, 32'h0100_0000, 32'hFFFF_FFFF,
                     32'd0, 16'h8000, 10'd1023, 10'd1023, 10'd1023);
        cmd_q.push_back(load_cmd(0, 16'h7FFF, 16'h8000, 16'h0001));
        cmd_q.push_back(load_cmd(1, 16'h8000, 16'h7FFF, 16'hFFFF));
        cmd_q.push_back(load_cmd(1023, 16'($urandom), 16'($urandom), 16'($urandom)));
        cmd_q.push_back(load_cmd(1024, 16'($urandom), 16'($urandom), 16'($urandom)));
        cmd_q.push_back(load_cmd(1046529, 16'($urandom), 16'($urandom), 16'($urandom)));
        cmd_q.push_back(load_cmd(1046530, 16'($urandom), 16'($urandom), 16'($urandom)));
        cmd_q.push_back(load_cmd(1047552, 16'($urandom), 16'($urandom), 16'($urandom)));
        cmd_q.push_back(load_cmd(1047553, 16'($urandom), 16'($urandom), 16'($urandom)));
        // Exact grid point, half a step that rounds up, a quarter-step cell,
        // a gradient at the first cell, below the origin, and a cell past the grid edge.
        cmd_q.push_back(query_cmd(OP_NEAREST, 32'h8000_0000, 0, 32'h7FFF_FFFF));
        cmd_q.push_back(query_cmd(OP_NEAREST, 32'h8000_0080, 0, 32'h7FFF_FFFF));
        cmd_q.push_back(query_cmd(OP_TRILIN, 32'h8000_0040, 0, 32'h7FFF_FFFF));
        cmd_q.push_back(query_cmd(OP_GRAD, 32'h8000_0000, 0, 32'h7FFF_FFFF));
        cmd_q.push_back(query_cmd(OP_NEAREST, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF));
        cmd_q.push_back(query_cmd(OP_GRAD, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF));
        cmd_q.push_back(query_cmd(OP_NEAREST, 32'h8000_0000, 1, 32'h7FFF_FFFF));
        cmd_q.push_back(query_cmd(OP_TRILIN, 32'h8003_FE00, 0, 32'h7FFF_FFFF));

        program_grid(0, 0, 0, 32'h0100_0000, 32'h0100_0000, 32'h0100_0000, 16'h7FFF,
                     10'd1023, 10'd1023, 10'd1023);
        cmd_q.push_back(query_cmd(OP_TRILIN, 32'h80, 32'hC0, 32'h40));
        cmd_q.push_back(query_cmd(OP_GRAD, 0, 0, 0));
        cmd_q.push_back(query_cmd(OP_NEAREST, 0, 0, 32'h100));
        cmd_q.push_back(query_cmd(OP_NEAREST, 32'h100, 32'h100, 0));
        // Cells that lie inside the grid but past the end of the table, then outside it.
        cmd_q.push_back(query_cmd(OP_NEAREST, 0, 0, 32'h200));
        cmd_q.push_back(query_cmd(OP_TRILIN, 0, 0, 32'h100));
        cmd_q.push_back(query_cmd(OP_GRAD, 0, 0, 32'h100));
        cmd_q.push_back(query_cmd(OP_NEAREST, 32'h7FFF_FFFF, 0, 0));
        cmd_q.push_back(query_cmd(OP_TRILIN, 32'h8000_0000, 0, 0));

        // Random part: small grids, every point loaded before it is queried.
        for (int ph = 0; ph < 6; ph++) begin
            for (int a = 0; a < 3; a++)
                inv[a] = (ph == 5) ? $urandom : $urandom_range(32'h0004_0000, 32'h0800_0000);
            nx = (ph == 4) ? 1 : $urandom_range(1, 3);
            ny = $urandom_range(1, 3);
            nz = (ph == 3) ? 0 : $urandom_range(1, 3);
            program_grid($urandom_range(0, 1 << 21) - (1 << 20),
                         $urandom_range(0, 1 << 21) - (1 << 20),
                         $urandom_range(0, 1 << 21) - (1 << 20),
                         inv[0], inv[1], inv[2], 16'($urandom), 10'(nx), 10'(ny), 10'(nz));
            for (int k = 0; k < nx * ny * nz; k++)
                cmd_q.push_back(load_cmd(k, 16'($urandom), 16'($urandom), 16'($urandom)));
            for (int q = 0; q < 8; q++) begin
                // Halfway through, hold off until the pipeline has drained.
                if (q == 4)
                    while (cmd_q.size() != 0 || field_exp_q.size() != 0) @(posedge i_clk);
                if ($urandom_range(0, 7) == 0)
                    cmd_q.push_back(load_cmd($urandom_range(0, 1048575),
                                             16'($urandom), 16'($urandom), 16'($urandom)));
                cmd_q.push_back(random_query());
            end
        end

        wait_idle();
        $display("covered %0d config phases, %0d queries, %0d results checked",
                 n_phases, n_queries, n_results);
        $display("mismatches: %0d, results never seen: %0d", n_mismatch, field_exp_q.size());
        if (n_mismatch == 0 && field_exp_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ----- field_grid_interpolator_core.f -----
+incdir+rtl/core
rtl/core/fgi_pkg.sv
rtl/core/fgi_addr.sv
rtl/core/fgi_table.sv
rtl/core/fgi_math.sv
rtl/core/field_grid_interpolator_core.sv
tb/sv/field_grid_interpolator_core_tb.sv
